FILE: rtl/core/itd_pkg.sv
// ----------------------------------------------------------------------------
// itd_pkg: shared types and constants for the decimal ASCII converter
// Request and result payloads, the digit record passed from the converter
// front end to the character emitter, and the divide-by-ten helper.
// ----------------------------------------------------------------------------
`default_nettype none

package itd_pkg;

  // Field widths
  localparam int ITD_VALUE_W   = 32;
  localparam int ITD_CHAR_W    = 7;
  localparam int ITD_DIGIT_W   = 4;
  localparam int ITD_MAX_DIGITS = 10;
  localparam int ITD_IDX_W     = 4;   // holds 0..ITD_MAX_DIGITS

  // Default depth of the digit record queue
  localparam int ITD_QUEUE_DEPTH = 2;

  // Command codes
  localparam logic ITD_CMD_UNSIGNED = 1'b0;
  localparam logic ITD_CMD_SIGNED   = 1'b1;

  // Characters
  localparam logic [ITD_CHAR_W-1:0] ITD_ASCII_ZERO  = 7'd48;
  localparam logic [ITD_CHAR_W-1:0] ITD_ASCII_MINUS = 7'd45;

  // floor(n / 10) == (n * 0xCCCCCCCD) >> 35 for every 32-bit n
  localparam logic [ITD_VALUE_W-1:0] ITD_RECIP10     = 32'hCCCC_CCCD;
  localparam int                     ITD_RECIP_SHIFT = 35;

  typedef struct packed {
    logic                   cmd;
    logic [ITD_VALUE_W-1:0] value;
  } itd_in_t;

  typedef struct packed {
    logic [ITD_CHAR_W-1:0] char_out;
    logic                  last;
  } itd_out_t;

  typedef logic [ITD_MAX_DIGITS-1:0][ITD_DIGIT_W-1:0] itd_digits_t;

  // One converted value: sign, digit count, digits least significant first
  typedef struct packed {
    logic                 neg;
    logic [ITD_IDX_W-1:0] ndig;
    itd_digits_t          digits;
  } itd_rec_t;

  function automatic logic [ITD_VALUE_W-1:0] itd_div10(input logic [ITD_VALUE_W-1:0] n);
    logic [2*ITD_VALUE_W-1:0] prod;
    prod = n * ITD_RECIP10;
    return ITD_VALUE_W'(prod >> ITD_RECIP_SHIFT);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/itd_front.sv
// ----------------------------------------------------------------------------
// itd_front: request intake and binary to decimal digit conversion
// Takes a request, forms sign and magnitude, then peels one decimal digit per
// cycle (least significant first) with a registered divide-by-ten.
// ----------------------------------------------------------------------------
`default_nettype none

module itd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire itd_pkg::itd_in_t in_data,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output itd_pkg::itd_rec_t     push_rec
);
  import itd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_DIGIT,
    ST_HOLD
  } state_t;

  state_t                 state_r, state_nxt;
  logic [ITD_VALUE_W-1:0] a_r;       // current dividend
  logic [ITD_VALUE_W-1:0] q_r;       // a_r / 10
  logic [ITD_IDX_W-1:0]   idx_r;     // digit being written
  logic [ITD_IDX_W-1:0]   ndig_r;
  logic                   neg_r;
  itd_digits_t            digits_r;

  logic                   is_neg;
  logic [ITD_VALUE_W-1:0] mag;
  logic [ITD_DIGIT_W-1:0] q10_lo;
  logic [ITD_DIGIT_W-1:0] rem;

  // Sign and magnitude of the incoming word
  assign is_neg = (in_data.cmd == ITD_CMD_SIGNED) && in_data.value[ITD_VALUE_W-1];
  assign mag    = is_neg ? (~in_data.value + 1'b1) : in_data.value;

  // Remainder a - 10*q fits in four bits, so only the low bits matter
  assign q10_lo = {q_r[0], 3'b000} + {q_r[2:0], 1'b0};
  assign rem    = a_r[ITD_DIGIT_W-1:0] - q10_lo;

  assign in_ready   = (state_r == ST_IDLE);
  assign push_valid = (state_r == ST_HOLD);
  assign push_rec   = '{neg: neg_r, ndig: ndig_r, digits: digits_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_PRIME;
      ST_PRIME: state_nxt = ST_DIGIT;
      ST_DIGIT: if (q_r == '0) state_nxt = ST_HOLD;
      ST_HOLD:  if (push_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          a_r   <= mag;
          neg_r <= is_neg;
          idx_r <= '0;
        end
      end
      ST_PRIME: begin
        q_r <= itd_div10(a_r);
      end
      ST_DIGIT: begin
        digits_r[idx_r] <= rem;
        if (q_r == '0) begin
          ndig_r <= idx_r + 1'b1;
        end else begin
          a_r   <= q_r;
          q_r   <= itd_div10(q_r);
          idx_r <= idx_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/itd_queue.sv
// ----------------------------------------------------------------------------
// itd_queue: small FIFO of digit records
// Decouples the converter from the character emitter so each can stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module itd_queue #(
  parameter int DEPTH = itd_pkg::ITD_QUEUE_DEPTH   // 2 or more
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire itd_pkg::itd_rec_t push_rec,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output itd_pkg::itd_rec_t      pop_rec
);
  import itd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  itd_rec_t           entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_rec    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/itd_emit.sv
// ----------------------------------------------------------------------------
// itd_emit: character emitter
// Pops a digit record and sends its text, sign first, most significant digit
// first, through a registered output; one character per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module itd_emit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  input  wire itd_pkg::itd_rec_t pop_rec,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output itd_pkg::itd_out_t      out_data
);
  import itd_pkg::*;

  logic                 busy_r;
  logic                 neg_r;
  logic [ITD_IDX_W-1:0] didx_r;     // next digit to send
  itd_digits_t          digits_r;
  logic                 out_valid_r;
  itd_out_t             out_data_r;
  logic                 slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign pop_ready = !busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!busy_r) begin
        // Output slot drains when taken
        if (out_ready) begin
          out_valid_r <= 1'b0;
        end
        // Load the next record
        if (pop_valid) begin
          busy_r   <= 1'b1;
          neg_r    <= pop_rec.neg;
          didx_r   <= pop_rec.ndig - 1'b1;
          digits_r <= pop_rec.digits;
        end
      end else if (slot_free) begin
        // Send one character
        out_valid_r <= 1'b1;
        if (neg_r) begin
          neg_r      <= 1'b0;
          out_data_r <= '{char_out: ITD_ASCII_MINUS, last: 1'b0};
        end else begin
          out_data_r <= '{char_out: ITD_ASCII_ZERO + {3'b000, digits_r[didx_r]},
                          last: (didx_r == '0)};
          if (didx_r == '0) begin
            busy_r <= 1'b0;
          end else begin
            didx_r <= didx_r - 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii: 32-bit word to decimal ASCII text
// Request channel in_*: {cmd, value}; cmd selects unsigned or signed reading.
// Result channel out_*: one {char_out, last} per character, 1 to 11 per
// request, sign first, most significant digit first, last set on the final
// character. Zero gives "0"; 0x80000000 read signed gives "-2147483648".
// Both channels use valid/ready.
// After a request is taken, the front end primes the divide-by-ten, runs
// its digit states and pushes the record to the queue; the emitter loads
// it and sends each character through its output register.
// The digit loop in the front end sets the sustained rate.
// The record queue lets the next request be converted while the text of the
// previous one is still being sent. When the receiver stalls, the output
// register holds its character, the queue fills, and in_ready drops.
// Reset (rst_n low, synchronous) returns the converter and emitter to idle
// and empties the queue and output register; datapath registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_decimal_ascii #(
  parameter int QUEUE_DEPTH = itd_pkg::ITD_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire itd_pkg::itd_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output itd_pkg::itd_out_t     out_data
);
  import itd_pkg::*;

  logic     push_valid, push_ready;
  itd_rec_t push_rec;
  logic     pop_valid, pop_ready;
  itd_rec_t pop_rec;

  itd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  itd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  itd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_rec   (pop_rec),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/core/itd_checker.sv
// ----------------------------------------------------------------------------
// itd_checker: port-level checks for int_to_decimal_ascii
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module itd_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire itd_pkg::itd_out_t out_data
);
  import itd_pkg::*;

  // Reset leaves the block empty and ready for a request
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("itd: not idle after reset");

  // A stalled result keeps valid and its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("itd: stalled result changed");

  // Only a sign or a decimal digit is ever sent
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.char_out == ITD_ASCII_MINUS ||
                   (out_data.char_out >= ITD_ASCII_ZERO &&
                    out_data.char_out <= ITD_ASCII_ZERO + 7'd9)))
    else $error("itd: bad character");

  // The sign is never the final character of a value
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.char_out == ITD_ASCII_MINUS) |-> !out_data.last)
    else $error("itd: sign marked last");

endmodule

bind int_to_decimal_ascii itd_checker u_itd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
